// ===== rtl/mms_pkg.sv =====
// mms_pkg: shared types and constants for the min/max stack.
// Used by every module of the block; depends on nothing.
package mms_pkg;

    localparam int DATA_W        = 32;
    localparam int STACK_DEPTH_D = 1024;

    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_POP  = 3'd1;
    localparam logic [2:0] OP_TOP  = 3'd2;
    localparam logic [2:0] OP_MAX  = 3'd3;
    localparam logic [2:0] OP_MIN  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [DATA_W-1:0] push_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] read_data;
    } t_out_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] max;
        logic signed [DATA_W-1:0] min;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REFILL
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic refill;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
        logic need_refill;
    } t_dp_status;

endpackage

// ===== rtl/mms_ctrl.sv =====
// mms_ctrl: command sequencer for the min/max stack.
// Depends on mms_pkg for state and command/status types.
module mms_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mms_pkg::t_dp_status i_sts,
    output mms_pkg::t_dp_cmd    o_cmd
);

    mms_pkg::t_state r_state;
    mms_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mms_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            mms_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = mms_pkg::S_EXEC;
                end
            end
            mms_pkg::S_EXEC: begin
                if (!i_sts.out_busy) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_sts.need_refill ? mms_pkg::S_REFILL : mms_pkg::S_IDLE;
                end
            end
            mms_pkg::S_REFILL: begin
                o_cmd.refill = 1'b1;
                n_state      = mms_pkg::S_IDLE;
            end
            default: begin
                n_state = mms_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mms_dp.sv =====
// mms_dp: stack datapath; top entry in registers, lower entries in a memory,
// result register on the output side. Depends on mms_pkg.
module mms_dp #(
    parameter int STACK_DEPTH = mms_pkg::STACK_DEPTH_D
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mms_pkg::t_in_word   i_in_word,
    input  mms_pkg::t_dp_cmd    i_cmd,
    output mms_pkg::t_dp_status o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mms_pkg::t_out_word  o_out_word
);

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    mms_pkg::t_entry r_mem [STACK_DEPTH];

    logic [2:0]                        r_op;
    logic signed [mms_pkg::DATA_W-1:0] r_val;
    logic [CNT_W-1:0]                  r_count;
    logic [CNT_W-1:0]                  n_count;
    mms_pkg::t_entry                   r_top;
    mms_pkg::t_entry                   n_top;
    mms_pkg::t_entry                   r_rd;
    logic                              r_out_valid;
    mms_pkg::t_out_word                r_out;
    mms_pkg::t_out_word                n_out;

    logic             full;
    logic             empty;
    logic             wr_en;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] cnt_m2;

    assign full   = (r_count == CNT_W'(STACK_DEPTH));
    assign empty  = (r_count == '0);
    assign cnt_m1 = r_count - CNT_W'(1);
    assign cnt_m2 = r_count - CNT_W'(2);
    assign wr_en  = i_cmd.exec && (r_op == mms_pkg::OP_PUSH) && !full && !empty;

    always_comb begin
        n_out           = '0;
        n_out.status    = mms_pkg::ST_OK;
        n_count         = r_count;
        n_top           = r_top;
        case (r_op)
            mms_pkg::OP_PUSH: begin
                if (full) begin
                    n_out.status = mms_pkg::ST_OVERFLOW;
                end else begin
                    n_count     = r_count + CNT_W'(1);
                    n_top.value = r_val;
                    if (empty) begin
                        n_top.max = r_val;
                        n_top.min = r_val;
                    end else begin
                        n_top.max = ($signed(r_val) > $signed(r_top.max)) ? r_val : r_top.max;
                        n_top.min = ($signed(r_val) < $signed(r_top.min)) ? r_val : r_top.min;
                    end
                end
            end
            mms_pkg::OP_POP: begin
                if (empty) begin
                    n_out.status = mms_pkg::ST_UNDERFLOW;
                end else begin
                    n_count = cnt_m1;
                end
            end
            mms_pkg::OP_TOP, mms_pkg::OP_MAX, mms_pkg::OP_MIN: begin
                if (empty) begin
                    n_out.status = mms_pkg::ST_EMPTY;
                end else if (r_op == mms_pkg::OP_TOP) begin
                    n_out.read_data = r_top.value;
                end else if (r_op == mms_pkg::OP_MAX) begin
                    n_out.read_data = r_top.max;
                end else begin
                    n_out.read_data = r_top.min;
                end
            end
            default: begin
                n_out.status = mms_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[cnt_m1[ADDR_W-1:0]] <= r_top;
        end
        r_rd <= r_mem[cnt_m2[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_word.opcode;
            r_val <= i_in_word.push_value;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
            r_top <= n_top;
        end else if (i_cmd.refill) begin
            r_top <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_busy    = r_out_valid && !i_out_ready;
    assign o_sts.need_refill = (r_op == mms_pkg::OP_POP) && (r_count > CNT_W'(1));
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out;

endmodule

// ===== rtl/min_max_stack.sv =====
// min_max_stack: top level of the bounded stack with running max/min.
// Instantiates mms_ctrl and mms_dp; depends on mms_pkg.
//
// Each accepted word is one command (push, pop, read top/max/min) and yields
// exactly one result word of status and data. A command passes the accept
// and execute states before the next ready; a pop that leaves one or more
// entries also passes a refill state, as the new top entry is fetched from
// the stack memory through its registered read port. Results sit in an output
// register, so the next command is taken while a result waits; execution stalls
// only if that register is still full. No clearing pass is needed after reset.
module min_max_stack #(
    parameter int STACK_DEPTH = mms_pkg::STACK_DEPTH_D
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mms_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mms_pkg::t_out_word o_out_word
);

    mms_pkg::t_dp_cmd    cmd;
    mms_pkg::t_dp_status sts;

    mms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mms_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== rtl/mms_checker.sv =====
// mms_checker: port-level checks for min_max_stack, bound to the top level.
// Depends on mms_pkg and min_max_stack.
module mms_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input mms_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input mms_pkg::t_out_word o_out_word
);

    // result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result dropped before taken");

    // one command in flight
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("word accepted while command in flight");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.read_data != '0) |->
            o_out_word.status == mms_pkg::ST_OK)
        else $error("nonzero data with error status");

    a_rst_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind min_max_stack mms_checker u_mms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
